[hdl/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define OSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define OSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/osp_pkg.sv]
// types and constants for the occupancy source priority fusion block
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package osp_pkg;

    localparam int LVL_W = 2;
    localparam int CNT_W = 16;
    localparam int TMO_W = 32;

    // input modes
    localparam logic [2:0] MODE_REGISTER   = 3'd0;
    localparam logic [2:0] MODE_UNREGISTER = 3'd1;
    localparam logic [2:0] MODE_UPDATE     = 3'd2;
    localparam logic [2:0] MODE_TRIGGER    = 3'd3;
    localparam logic [2:0] MODE_SET_ACTIVE = 3'd4;
    localparam logic [2:0] MODE_TICK       = 3'd5;

    // error codes
    localparam logic [1:0] ERR_OK     = 2'd0;
    localparam logic [1:0] ERR_BAD_ID = 2'd1;
    localparam logic [1:0] ERR_FULL   = 2'd2;

    localparam logic [TMO_W-1:0] LONG_TIMEOUT_RESET = 32'd60000;
    localparam logic [TMO_W-1:0] ELAPSED_MAX        = 32'hFFFF_FFFF;
    localparam logic signed [CNT_W-1:0] COUNT_UNKNOWN = -16'sd1;

    // slot table write operations
    typedef enum logic [2:0] {
        WR_NONE,
        WR_REGISTER,
        WR_UNREGISTER,
        WR_UPDATE,
        WR_TRIGGER,
        WR_SET_ACTIVE,
        WR_TICK
    } t_wr_op;

    // one slot as read from the table
    typedef struct packed {
        logic                    valid;
        logic                    active;
        logic                    triggered;
        logic [LVL_W-1:0]        level;
        logic [TMO_W-1:0]        timeout;
        logic [TMO_W-1:0]        elapsed;
        logic signed [CNT_W-1:0] count;
        logic                    certain;
        logic                    ever_updated;
    } t_slot;

    // write command into the slot table
    typedef struct packed {
        t_wr_op                  op;
        logic [LVL_W-1:0]        level;
        logic                    triggered;
        logic [TMO_W-1:0]        timeout;
        logic signed [CNT_W-1:0] count;
        logic                    certain;
        logic signed [CNT_W-1:0] min_count;
        logic                    active;
    } t_slot_wr;

    // running best candidates of the fusion scan
    typedef struct packed {
        logic                    pos_found;
        logic [LVL_W-1:0]        pos_lvl;
        logic                    pos_cert;
        logic signed [CNT_W-1:0] pos_cnt;
        logic                    zero_found;
        logic [LVL_W-1:0]        zero_lvl;
        logic                    zero_cert;
    } t_best;

    // which candidate the current slot replaces
    typedef struct packed {
        logic take_pos;
        logic take_zero;
    } t_take;

endpackage

[hdl/osp_slot_file.sv]
// source slot table: per-slot fields, one read/write index
// depends on osp_pkg
`timescale 1ns / 1ps

module osp_slot_file #(
    parameter int NUM_SOURCES = 8,
    localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [IDX_W-1:0]        i_idx,
    input  osp_pkg::t_slot_wr       i_wr,
    output osp_pkg::t_slot          o_rd,
    output logic [NUM_SOURCES-1:0]  o_valid
);

    logic [NUM_SOURCES-1:0]            r_valid;
    logic                              r_active    [NUM_SOURCES];
    logic                              r_triggered [NUM_SOURCES];
    logic [osp_pkg::LVL_W-1:0]         r_level     [NUM_SOURCES];
    logic [osp_pkg::TMO_W-1:0]         r_timeout   [NUM_SOURCES];
    logic [osp_pkg::TMO_W-1:0]         r_elapsed   [NUM_SOURCES];
    logic signed [osp_pkg::CNT_W-1:0]  r_count     [NUM_SOURCES];
    logic                              r_certain   [NUM_SOURCES];
    logic                              r_ever      [NUM_SOURCES];

    logic                              idx_ok;
    logic signed [osp_pkg::CNT_W-1:0]  trig_base;
    logic signed [osp_pkg::CNT_W-1:0]  trig_count;

    assign idx_ok  = int'(i_idx) < NUM_SOURCES;
    assign o_valid = r_valid;

    always_comb begin
        o_rd = '0;
        if (idx_ok) begin
            o_rd.valid        = r_valid[i_idx];
            o_rd.active       = r_active[i_idx];
            o_rd.triggered    = r_triggered[i_idx];
            o_rd.level        = r_level[i_idx];
            o_rd.timeout      = r_timeout[i_idx];
            o_rd.elapsed      = r_elapsed[i_idx];
            o_rd.count        = r_count[i_idx];
            o_rd.certain      = r_certain[i_idx];
            o_rd.ever_updated = r_ever[i_idx];
        end
    end

    // presence trigger raises the count to at least min_count
    always_comb begin
        trig_base  = o_rd.ever_updated ? $signed(o_rd.count) : '0;
        trig_count = (trig_base > $signed(i_wr.min_count)) ? trig_base
                                                           : $signed(i_wr.min_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (idx_ok) begin
            case (i_wr.op)
                osp_pkg::WR_REGISTER:   r_valid[i_idx] <= 1'b1;
                osp_pkg::WR_UNREGISTER: r_valid[i_idx] <= 1'b0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (idx_ok) begin
            case (i_wr.op)
                osp_pkg::WR_REGISTER: begin
                    r_level[i_idx]     <= i_wr.level;
                    r_triggered[i_idx] <= i_wr.triggered;
                    r_timeout[i_idx]   <= i_wr.timeout;
                    r_count[i_idx]     <= i_wr.count;
                    r_certain[i_idx]   <= !i_wr.count[osp_pkg::CNT_W-1];
                    r_ever[i_idx]      <= !i_wr.count[osp_pkg::CNT_W-1];
                    r_active[i_idx]    <= 1'b1;
                    r_elapsed[i_idx]   <= '0;
                end
                osp_pkg::WR_UPDATE: begin
                    r_count[i_idx]   <= i_wr.count;
                    r_certain[i_idx] <= i_wr.certain;
                    r_elapsed[i_idx] <= '0;
                    r_ever[i_idx]    <= 1'b1;
                end
                osp_pkg::WR_TRIGGER: begin
                    r_count[i_idx]   <= trig_count;
                    r_certain[i_idx] <= 1'b0;
                    r_elapsed[i_idx] <= '0;
                    r_ever[i_idx]    <= 1'b1;
                end
                osp_pkg::WR_SET_ACTIVE: begin
                    r_active[i_idx] <= i_wr.active;
                end
                osp_pkg::WR_TICK: begin
                    if (o_rd.valid && o_rd.elapsed != osp_pkg::ELAPSED_MAX) begin
                        r_elapsed[i_idx] <= o_rd.elapsed + 32'd1;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

[hdl/osp_fuse_unit.sv]
// shared fusion step: judges one slot and updates the running best candidates
// depends on osp_pkg
`timescale 1ns / 1ps

module osp_fuse_unit #(
    parameter int NUM_LEVELS = 4
) (
    input  osp_pkg::t_slot             i_slot,
    input  logic [osp_pkg::TMO_W-1:0]  i_long_timeout,
    input  osp_pkg::t_best             i_best,
    output osp_pkg::t_best             o_best,
    output osp_pkg::t_take             o_take
);

    logic timed_out;
    logic disq_timeout;
    logic eligible;
    logic lvl_ok;
    logic is_pos;
    logic is_zero;

    always_comb begin
        timed_out    = (i_slot.timeout != '0) && (i_slot.elapsed > i_slot.timeout);
        disq_timeout = timed_out && (!i_slot.triggered || (i_slot.timeout > i_long_timeout));
        eligible     = i_slot.valid && i_slot.active && !i_slot.count[osp_pkg::CNT_W-1]
                       && !(i_slot.triggered && !i_slot.ever_updated) && !disq_timeout;
        lvl_ok       = int'(i_slot.level) < NUM_LEVELS;
        is_pos       = eligible && lvl_ok && (i_slot.count != '0);
        is_zero      = eligible && lvl_ok && (i_slot.count == '0);

        // higher level wins; same level: first certain, else last uncertain
        o_take.take_pos  = is_pos && (!i_best.pos_found || (i_slot.level > i_best.pos_lvl)
                           || ((i_slot.level == i_best.pos_lvl) && !i_best.pos_cert));
        // zero-count fallback: highest level, lowest slot
        o_take.take_zero = is_zero && (!i_best.zero_found || (i_slot.level > i_best.zero_lvl));

        o_best = i_best;
        if (o_take.take_pos) begin
            o_best.pos_found = 1'b1;
            o_best.pos_lvl   = i_slot.level;
            o_best.pos_cert  = i_slot.certain;
            o_best.pos_cnt   = i_slot.count;
        end
        if (o_take.take_zero) begin
            o_best.zero_found = 1'b1;
            o_best.zero_lvl   = i_slot.level;
            o_best.zero_cert  = i_slot.certain;
        end
    end

endmodule

[hdl/occupancy_source_priority_fusion_core.sv]
// occupancy source priority fusion, top level: sequencer, fused status, config
// a recompute item steps through S_EXEC, S_SCAN, S_FUSE and S_DONE; a tick item through S_EXEC,
// S_TICK and S_DONE; an error or no-op item through S_EXEC and S_DONE. the scan takes one slot per cycle through
// the shared fusion unit. results cannot be stalled: o_done is a one-cycle strobe
// synchronous active-low reset empties the slot table, sets fused status to none
// (count -1, source NUM_SOURCES) and long timeout to 60000 ms
`timescale 1ns / 1ps

module occupancy_source_priority_fusion_core #(
    parameter int NUM_SOURCES = 8,
    parameter int NUM_LEVELS  = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command channel
    input  logic               i_start,
    output logic               o_busy,
    input  logic [2:0]         i_mode,
    input  logic [2:0]         i_source_id,
    input  logic [1:0]         i_reliability,
    input  logic               i_source_kind,
    input  logic [31:0]        i_timeout_ms,
    input  logic signed [15:0] i_count,
    input  logic               i_certain,
    input  logic signed [15:0] i_min_count,
    input  logic               i_active,
    // configuration write
    input  logic               i_cfg_wr_en,
    input  logic [31:0]        i_cfg_wr_data,
    // result beat
    output logic               o_done,
    output logic [1:0]         o_error,
    output logic [2:0]         o_assigned_id,
    output logic signed [15:0] o_status_count,
    output logic               o_occupied,
    output logic               o_count_certain,
    output logic [3:0]         o_status_source,
    output logic [1:0]         o_status_reliability,
    output logic               o_changed
);

    localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int SRC_W = $clog2(NUM_SOURCES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SOURCES - 1);
    localparam logic [SRC_W-1:0] SRC_NONE = SRC_W'(NUM_SOURCES);

    // sequencer states
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,  // waiting for a command beat
        S_EXEC = 6'b000010,  // check slot id, write the addressed slot
        S_SCAN = 6'b000100,  // one slot per cycle through the fusion unit
        S_TICK = 6'b001000,  // one slot per cycle, elapsed counter bump
        S_FUSE = 6'b010000,  // form new fused status, compare with old
        S_DONE = 6'b100000   // result beat on the outputs
    } t_state;

    t_state r_state, n_state;

    // latched command
    logic [2:0]                r_mode;
    logic                      r_id_in_range;
    logic                      r_free_found;
    logic [1:0]                r_reliability;
    logic                      r_source_kind;
    logic [31:0]               r_timeout_ms;
    logic signed [15:0]        r_count;
    logic                      r_certain;
    logic signed [15:0]        r_min_count;
    logic                      r_active;

    logic [31:0]               r_long_timeout;

    // slot index shared by exec write, scan and tick
    logic [IDX_W-1:0]          r_idx, n_idx;

    // scan candidates
    osp_pkg::t_best            r_best, n_best;
    logic [IDX_W-1:0]          r_pos_idx, n_pos_idx;
    logic [IDX_W-1:0]          r_zero_idx, n_zero_idx;

    // fused status
    logic signed [15:0]        r_fused_cnt, n_fused_cnt;
    logic                      r_fused_occ, n_fused_occ;
    logic                      r_fused_cert, n_fused_cert;
    logic [SRC_W-1:0]          r_fused_src, n_fused_src;
    logic [1:0]                r_fused_lvl, n_fused_lvl;

    // result fields
    logic [1:0]                r_error, n_error;
    logic [IDX_W-1:0]          r_assigned, n_assigned;
    logic                      r_changed, n_changed;

    // slot table and fusion unit hookup
    osp_pkg::t_slot_wr         slot_wr;
    osp_pkg::t_slot            slot_rd;
    logic [NUM_SOURCES-1:0]    slot_valid;
    osp_pkg::t_best            fuse_best;
    osp_pkg::t_take            fuse_take;

    // accept-time helpers
    logic                      accept;
    logic                      free_found;
    logic [IDX_W-1:0]          free_idx;
    logic [IDX_W+2:0]          id_ext;
    logic [IDX_W-1:0]          id_idx;
    logic                      id_in_range;

    osp_slot_file #(
        .NUM_SOURCES (NUM_SOURCES)
    ) u_slots (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_idx   (r_idx),
        .i_wr    (slot_wr),
        .o_rd    (slot_rd),
        .o_valid (slot_valid)
    );

    osp_fuse_unit #(
        .NUM_LEVELS (NUM_LEVELS)
    ) u_fuse (
        .i_slot         (slot_rd),
        .i_long_timeout (r_long_timeout),
        .i_best         (r_best),
        .o_best         (fuse_best),
        .o_take         (fuse_take)
    );

    assign accept = i_start && (r_state == S_IDLE);

    // lowest free slot for register
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int k = NUM_SOURCES - 1; k >= 0; k--) begin
            if (!slot_valid[k]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(k);
            end
        end
    end

    assign id_ext      = (IDX_W + 3)'(i_source_id);
    assign id_idx      = id_ext[IDX_W-1:0];
    assign id_in_range = int'(i_source_id) < NUM_SOURCES;

    // command payload, held for the whole item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode        <= i_mode;
            r_id_in_range <= id_in_range;
            r_free_found  <= free_found;
            r_reliability <= i_reliability;
            r_source_kind <= i_source_kind;
            r_timeout_ms  <= i_timeout_ms;
            r_count       <= i_count;
            r_certain     <= i_certain;
            r_min_count   <= i_min_count;
            r_active      <= i_active;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_timeout <= osp_pkg::LONG_TIMEOUT_RESET;
        end else if (i_cfg_wr_en) begin
            r_long_timeout <= i_cfg_wr_data;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_best       = r_best;
        n_pos_idx    = r_pos_idx;
        n_zero_idx   = r_zero_idx;
        n_fused_cnt  = r_fused_cnt;
        n_fused_occ  = r_fused_occ;
        n_fused_cert = r_fused_cert;
        n_fused_src  = r_fused_src;
        n_fused_lvl  = r_fused_lvl;
        n_error      = r_error;
        n_assigned   = r_assigned;
        n_changed    = r_changed;

        slot_wr           = '0;
        slot_wr.op        = osp_pkg::WR_NONE;
        slot_wr.level     = r_reliability;
        slot_wr.triggered = r_source_kind;
        slot_wr.timeout   = r_timeout_ms;
        slot_wr.count     = r_count;
        slot_wr.certain   = r_certain;
        slot_wr.min_count = r_min_count;
        slot_wr.active    = r_active;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_error    = osp_pkg::ERR_OK;
                    n_assigned = '0;
                    n_changed  = 1'b0;
                    // point the shared index at the slot the command touches
                    case (i_mode)
                        osp_pkg::MODE_REGISTER: n_idx = free_idx;
                        osp_pkg::MODE_TICK:     n_idx = '0;
                        default:                n_idx = id_idx;
                    endcase
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_best     = '0;
                n_pos_idx  = '0;
                n_zero_idx = '0;
                unique case (r_mode)
                    osp_pkg::MODE_REGISTER: begin
                        if (r_free_found) begin
                            slot_wr.op = osp_pkg::WR_REGISTER;
                            n_assigned = r_idx;
                            n_idx      = '0;
                            n_state    = S_SCAN;
                        end else begin
                            n_error = osp_pkg::ERR_FULL;
                            n_state = S_DONE;
                        end
                    end
                    osp_pkg::MODE_UNREGISTER, osp_pkg::MODE_UPDATE,
                    osp_pkg::MODE_TRIGGER, osp_pkg::MODE_SET_ACTIVE: begin
                        if (!(r_id_in_range && slot_rd.valid)) begin
                            n_error = osp_pkg::ERR_BAD_ID;
                            n_state = S_DONE;
                        end else if (r_mode == osp_pkg::MODE_SET_ACTIVE
                                     && slot_rd.active == r_active) begin
                            // flag already as asked: no recompute
                            n_state = S_DONE;
                        end else begin
                            case (r_mode)
                                osp_pkg::MODE_UNREGISTER: slot_wr.op = osp_pkg::WR_UNREGISTER;
                                osp_pkg::MODE_UPDATE:     slot_wr.op = osp_pkg::WR_UPDATE;
                                osp_pkg::MODE_TRIGGER:    slot_wr.op = osp_pkg::WR_TRIGGER;
                                default:                  slot_wr.op = osp_pkg::WR_SET_ACTIVE;
                            endcase
                            n_idx   = '0;
                            n_state = S_SCAN;
                        end
                    end
                    osp_pkg::MODE_TICK: begin
                        n_state = S_TICK;
                    end
                    default: begin
                        // unused modes leave everything as it is
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                n_best = fuse_best;
                if (fuse_take.take_pos) begin
                    n_pos_idx = r_idx;
                end
                if (fuse_take.take_zero) begin
                    n_zero_idx = r_idx;
                end
                if (r_idx == LAST_IDX) begin
                    n_state = S_FUSE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_TICK: begin
                slot_wr.op = osp_pkg::WR_TICK;
                if (r_idx == LAST_IDX) begin
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_FUSE: begin
                // positive source beats the zero-count fallback
                if (r_best.pos_found) begin
                    n_fused_cnt  = r_best.pos_cnt;
                    n_fused_occ  = 1'b1;
                    n_fused_cert = r_best.pos_cert;
                    n_fused_src  = SRC_W'(r_pos_idx);
                    n_fused_lvl  = r_best.pos_lvl;
                end else if (r_best.zero_found) begin
                    n_fused_cnt  = '0;
                    n_fused_occ  = 1'b0;
                    n_fused_cert = r_best.zero_cert;
                    n_fused_src  = SRC_W'(r_zero_idx);
                    n_fused_lvl  = r_best.zero_lvl;
                end else begin
                    n_fused_cnt  = osp_pkg::COUNT_UNKNOWN;
                    n_fused_occ  = 1'b0;
                    n_fused_cert = 1'b0;
                    n_fused_src  = SRC_NONE;
                    n_fused_lvl  = '0;
                end
                n_changed = (n_fused_cnt != r_fused_cnt) || (n_fused_occ != r_fused_occ)
                            || (n_fused_cert != r_fused_cert) || (n_fused_src != r_fused_src)
                            || (n_fused_lvl != r_fused_lvl);
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fused_cnt  <= osp_pkg::COUNT_UNKNOWN;
            r_fused_occ  <= 1'b0;
            r_fused_cert <= 1'b0;
            r_fused_src  <= SRC_NONE;
            r_fused_lvl  <= '0;
        end else begin
            r_state      <= n_state;
            r_fused_cnt  <= n_fused_cnt;
            r_fused_occ  <= n_fused_occ;
            r_fused_cert <= n_fused_cert;
            r_fused_src  <= n_fused_src;
            r_fused_lvl  <= n_fused_lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_best     <= n_best;
        r_pos_idx  <= n_pos_idx;
        r_zero_idx <= n_zero_idx;
        r_error    <= n_error;
        r_assigned <= n_assigned;
        r_changed  <= n_changed;
    end

    // outputs straight from registers
    assign o_busy               = (r_state != S_IDLE);
    assign o_done               = (r_state == S_DONE);
    assign o_error              = r_error;
    assign o_assigned_id        = 3'(r_assigned);
    assign o_status_count       = r_fused_cnt;
    assign o_occupied           = r_fused_occ;
    assign o_count_certain      = r_fused_cert;
    assign o_status_source      = 4'(r_fused_src);
    assign o_status_reliability = r_fused_lvl;
    assign o_changed            = r_changed;

endmodule

[hdl/osp_checker.sv]
// port-level checker for the fusion core, attached by bind
// depends on assert_macros.svh and the top level's ports
`timescale 1ns / 1ps
`include "assert_macros.svh"

module osp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input logic               o_busy,
    input logic               o_done,
    input logic [1:0]         o_error,
    input logic [2:0]         o_assigned_id,
    input logic signed [15:0] o_status_count,
    input logic               o_occupied,
    input logic               o_changed
);

    // result beat only while an item is in flight
    `OSP_ASSERT_NOW(a_done_busy, i_clk, i_rst_n, o_done, o_busy, "result beat while idle")

    // an accepted command keeps the core busy next cycle
    `OSP_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy, "accept without busy")

    // a rejected command never alters the fused status
    `OSP_ASSERT_NOW(a_err_nochg, i_clk, i_rst_n, o_done && o_error != 2'd0, !o_changed, "error beat flagged changed")

    // occupied status always carries a positive count
    `OSP_ASSERT_NOW(a_occ_count, i_clk, i_rst_n, o_done && o_occupied, o_status_count > 16'sd0, "occupied with count below one")

    // full table gives no slot
    `OSP_ASSERT_NOW(a_full_id, i_clk, i_rst_n, o_done && o_error == 2'd2, o_assigned_id == 3'd0, "slot id on full table")

endmodule

bind occupancy_source_priority_fusion_core osp_checker u_osp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .o_busy         (o_busy),
    .o_done         (o_done),
    .o_error        (o_error),
    .o_assigned_id  (o_assigned_id),
    .o_status_count (o_status_count),
    .o_occupied     (o_occupied),
    .o_changed      (o_changed)
);
